@@ hw/rtl/cursor_sequence_store_macros.svh @@
// ----------------------------------------------------------------------------
// cursor_sequence_store_macros.svh
// Assertion macros shared by the cursor sequence store RTL.
// ----------------------------------------------------------------------------
`ifndef CURSOR_SEQUENCE_STORE_MACROS_SVH
`define CURSOR_SEQUENCE_STORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSS_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CSS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/css_pkg.sv @@
// ----------------------------------------------------------------------------
// css_pkg
// Request codes, status codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package css_pkg;

    typedef enum logic [3:0] {
        REQ_START        = 4'd0,
        REQ_END          = 4'd1,
        REQ_LAST         = 4'd2,
        REQ_ADVANCE      = 4'd3,
        REQ_RETREAT      = 4'd4,
        REQ_INSERT       = 4'd5,
        REQ_ATTACH       = 4'd6,
        REQ_REMOVE_CUR   = 4'd7,
        REQ_INSERT_FRONT = 4'd8,
        REQ_ATTACH_BACK  = 4'd9,
        REQ_REMOVE_FRONT = 4'd10,
        REQ_READ_AT      = 4'd11
    } t_req;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_NO_CUR = 2'd2,
        ST_RANGE  = 2'd3
    } t_status;

    // Kind of memory move that a request needs.
    typedef enum logic [1:0] {
        SH_NONE  = 2'd0,
        SH_OPEN  = 2'd1,
        SH_CLOSE = 2'd2
    } t_shift;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // latch a request and commit cursor and count
        logic step;      // read the next item to move
        logic fill;      // write the new word into the opened slot
        logic rd_cur;    // read the item under the cursor
        logic rd_pos;    // read the requested position
        logic out_load;  // load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic moves;     // item moves still pending
        logic at_last;   // the move address is the final one
        logic fill;      // the request writes a new word
    } t_dp_stat;

endpackage

@@ hw/rtl/css_ram.sv @@
// ----------------------------------------------------------------------------
// css_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module css_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/css_ctrl.sv @@
// ----------------------------------------------------------------------------
// css_ctrl
// Request sequencer: item moves, slot fill, result reads and result hand-off.
// ----------------------------------------------------------------------------
`include "cursor_sequence_store_macros.svh"

module css_ctrl
    import css_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_valid,
    output logic     o_s_ready,
    output logic     o_m_valid,
    input  logic     i_m_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_DRAIN,
        S_FILL,
        S_RD_CUR,
        S_RD_POS,
        S_RESP
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_vld;
    logic    n_out_vld;
    t_dp_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (i_stat.moves) begin
                    cmd.step = 1'b1;
                    if (i_stat.at_last) begin
                        n_state = S_DRAIN;
                    end
                end else begin
                    n_state = i_stat.fill ? S_FILL : S_RD_CUR;
                end
            end
            // The final moved item is written in this cycle.
            S_DRAIN: begin
                n_state = i_stat.fill ? S_FILL : S_RD_CUR;
            end
            S_FILL: begin
                cmd.fill = 1'b1;
                n_state  = S_RD_CUR;
            end
            S_RD_CUR: begin
                cmd.rd_cur = 1'b1;
                n_state    = S_RD_POS;
            end
            S_RD_POS: begin
                cmd.rd_pos = 1'b1;
                n_state    = S_RESP;
            end
            S_RESP: begin
                if (!r_out_vld || i_m_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_vld = cmd.out_load | (r_out_vld & ~i_m_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_out_vld;
    assign o_cmd     = cmd;

    `CSS_ASSERT_NEXT(a_one_item_in_flight, i_clk, i_rst_n, i_s_valid && o_s_ready, r_state != S_IDLE, "request accepted but sequencer stayed idle")

endmodule

@@ hw/rtl/css_datapath.sv @@
// ----------------------------------------------------------------------------
// css_datapath
// Request decode, cursor and count registers, item memory and result register.
// ----------------------------------------------------------------------------
`include "cursor_sequence_store_macros.svh"

module css_datapath
    import css_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32,
    localparam int AW        = $clog2(CAPACITY),
    localparam int CW        = $clog2(CAPACITY + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic [3:0]            i_req,
    input  logic [DATA_WIDTH-1:0] i_word,
    input  logic [AW-1:0]         i_pos,
    output logic [DATA_WIDTH-1:0] o_cur_value,
    output logic [DATA_WIDTH-1:0] o_read_value,
    output logic [CW-1:0]         o_item_count,
    output logic                  o_has_current,
    output t_status               o_status
);

    t_req req;

    // Committed state.
    logic [CW-1:0] r_cursor;
    logic [CW-1:0] r_count;

    // Latched request.
    logic [DATA_WIDTH-1:0] r_word;
    logic [AW-1:0]         r_pos;
    logic [AW-1:0]         r_slot;
    logic                  r_read_ok;
    t_status               r_status;
    logic                  r_fill;
    logic                  r_up;
    logic                  r_moves;
    logic [AW-1:0]         r_addr;
    logic [AW-1:0]         r_last;

    // Move pipeline: the item read in one cycle is written in the next.
    logic                  r_mv_vld;
    logic [AW-1:0]         r_mv_dst;

    logic [DATA_WIDTH-1:0] r_cur_val;

    // Result register.
    logic [DATA_WIDTH-1:0] r_o_cur;
    logic [DATA_WIDTH-1:0] r_o_rd;
    logic [CW-1:0]         r_o_cnt;
    logic                  r_o_hc;
    t_status               r_o_st;

    // Decode.
    t_status       n_status;
    logic [CW-1:0] n_cursor;
    logic [CW-1:0] n_count;
    t_shift        n_op;
    logic [CW-1:0] n_slot;
    logic          n_read_ok;
    logic          n_moves;
    logic [AW-1:0] n_addr;
    logic [AW-1:0] n_last;

    logic cur_vld;
    logic full;
    logic has_cur;

    // Memory port.
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    assign req     = t_req'(i_req);
    assign cur_vld = (r_cursor < r_count);
    assign full    = (r_count == CW'(CAPACITY));
    assign has_cur = (r_cursor < r_count);

    always_comb begin
        n_status  = ST_OK;
        n_cursor  = r_cursor;
        n_count   = r_count;
        n_op      = SH_NONE;
        n_slot    = '0;
        n_read_ok = 1'b0;
        unique case (req)
            REQ_START: begin
                n_cursor = '0;
            end
            REQ_END: begin
                n_cursor = (r_count != '0) ? r_count - 1'b1 : '0;
            end
            REQ_LAST: begin
                n_cursor = CW'(CAPACITY - 1);
            end
            REQ_ADVANCE: begin
                if (!cur_vld) begin
                    n_status = ST_NO_CUR;
                end else begin
                    n_cursor = r_cursor + 1'b1;
                end
            end
            REQ_RETREAT: begin
                if (r_cursor != '0) begin
                    n_cursor = r_cursor - 1'b1;
                end
            end
            REQ_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_op     = SH_OPEN;
                    n_slot   = cur_vld ? r_cursor : '0;
                    n_cursor = n_slot;
                    n_count  = r_count + 1'b1;
                end
            end
            REQ_ATTACH: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_op     = SH_OPEN;
                    n_slot   = cur_vld ? r_cursor + 1'b1 : r_count;
                    n_cursor = n_slot;
                    n_count  = r_count + 1'b1;
                end
            end
            REQ_INSERT_FRONT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_op     = SH_OPEN;
                    n_slot   = '0;
                    n_cursor = '0;
                    n_count  = r_count + 1'b1;
                end
            end
            REQ_ATTACH_BACK: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_op     = SH_OPEN;
                    n_slot   = r_count;
                    n_cursor = r_count;
                    n_count  = r_count + 1'b1;
                end
            end
            REQ_REMOVE_CUR: begin
                if (!cur_vld) begin
                    n_status = ST_NO_CUR;
                end else begin
                    n_op    = SH_CLOSE;
                    n_slot  = r_cursor;
                    n_count = r_count - 1'b1;
                end
            end
            REQ_REMOVE_FRONT: begin
                if (!cur_vld) begin
                    n_status = ST_NO_CUR;
                end else begin
                    n_op     = SH_CLOSE;
                    n_slot   = '0;
                    n_cursor = '0;
                    n_count  = r_count - 1'b1;
                end
            end
            REQ_READ_AT: begin
                if (CW'(i_pos) >= r_count) begin
                    n_status = ST_RANGE;
                end else begin
                    n_read_ok = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Opening a slot walks down from the last item to the slot; closing one
    // walks up from just above the slot to the last item.
    always_comb begin
        n_moves = 1'b0;
        n_addr  = '0;
        n_last  = '0;
        unique case (n_op)
            SH_OPEN: begin
                n_moves = (n_slot != r_count);
                n_addr  = AW'(r_count - 1'b1);
                n_last  = AW'(n_slot);
            end
            SH_CLOSE: begin
                n_moves = ((n_slot + 1'b1) < r_count);
                n_addr  = AW'(n_slot + 1'b1);
                n_last  = AW'(r_count - 1'b1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_count  <= '0;
            r_moves  <= 1'b0;
            r_fill   <= 1'b0;
            r_mv_vld <= 1'b0;
        end else begin
            r_mv_vld <= i_cmd.step;
            if (i_cmd.load) begin
                r_cursor <= n_cursor;
                r_count  <= n_count;
                r_moves  <= n_moves;
                r_fill   <= (n_op == SH_OPEN);
            end else if (i_cmd.step && (r_addr == r_last)) begin
                r_moves <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word    <= i_word;
            r_pos     <= i_pos;
            r_slot    <= AW'(n_slot);
            r_read_ok <= n_read_ok;
            r_status  <= n_status;
            r_up      <= (n_op == SH_OPEN);
            r_addr    <= n_addr;
            r_last    <= n_last;
        end else if (i_cmd.step) begin
            r_addr <= r_up ? r_addr - 1'b1 : r_addr + 1'b1;
        end
        if (i_cmd.step) begin
            r_mv_dst <= r_up ? r_addr + 1'b1 : r_addr - 1'b1;
        end
        // The cursor read issued in S_RD_CUR lands here.
        if (i_cmd.rd_pos) begin
            r_cur_val <= mem_rdata;
        end
        if (i_cmd.out_load) begin
            r_o_cur <= has_cur ? r_cur_val : '0;
            r_o_rd  <= r_read_ok ? mem_rdata : '0;
            r_o_cnt <= r_count;
            r_o_hc  <= has_cur;
            r_o_st  <= r_status;
        end
    end

    assign mem_we    = r_mv_vld | i_cmd.fill;
    assign mem_waddr = r_mv_vld ? r_mv_dst : r_slot;
    assign mem_wdata = r_mv_vld ? mem_rdata : r_word;
    assign mem_re    = i_cmd.step | i_cmd.rd_cur | i_cmd.rd_pos;

    always_comb begin
        priority if (i_cmd.step) begin
            mem_raddr = r_addr;
        end else if (i_cmd.rd_cur) begin
            mem_raddr = AW'(r_cursor);
        end else begin
            mem_raddr = r_pos;
        end
    end

    css_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_items (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_stat.moves   = r_moves;
    assign o_stat.at_last = (r_addr == r_last);
    assign o_stat.fill    = r_fill;

    assign o_cur_value   = r_o_cur;
    assign o_read_value  = r_o_rd;
    assign o_item_count  = r_o_cnt;
    assign o_has_current = r_o_hc;
    assign o_status      = r_o_st;

    `CSS_ASSERT_IMPL(a_write_port_single, i_clk, i_rst_n, r_mv_vld, !i_cmd.fill, "item move and slot fill collide on the write port")
    `CSS_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY), "item count above capacity")
    `CSS_ASSERT_NEXT(a_error_keeps_state, i_clk, i_rst_n, i_cmd.load && (n_status != ST_OK), (r_count == $past(r_count)) && (r_cursor == $past(r_cursor)), "rejected request changed cursor or count")

endmodule

@@ hw/rtl/cursor_sequence_store.sv @@
// ----------------------------------------------------------------------------
// cursor_sequence_store
// An ordered store of up to CAPACITY words with a cursor. Each request beat
// moves the cursor, inserts or attaches a word (later items shift up),
// removes an item (later items shift down) or reads an item by position, and
// yields exactly one result beat with the current item, the item count, a
// has-current flag and a status code. Requests are handled one at a time.
// The items live in a single RAM with one write and one registered read
// port, and item moves go through that RAM at one item per cycle, so the
// cost of a request is set by how many items it moves. After the beat is
// accepted, a request walks its item moves, writes the new word (insert and
// attach only), reads the current item and the requested position, and then
// loads the result register. The result beat is valid from the cycle after
// the load, and the next request beat can be taken in that same cycle. The
// worst case at the default capacity is an insert at the front of 63 held
// items. A result that finds the output register still full waits until
// that register is taken, which adds those stall cycles. A new request is
// accepted while the previous result still waits on the output. The item
// memory is not cleared at reset and needs no clearing pass; items beyond
// the count are never reported.
// ----------------------------------------------------------------------------
module cursor_sequence_store
    import css_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32,
    localparam int AW        = $clog2(CAPACITY),
    localparam int CW        = $clog2(CAPACITY + 1),
    localparam int IDW       = ((DATA_WIDTH + AW + 7) / 8) * 8,
    localparam int ODW       = ((2 * DATA_WIDTH + CW + 7) / 8) * 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,

    // Request stream.
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [IDW-1:0] s_axis_tdata,   // entry_value, position, zero fill
    input  logic [3:0]     s_axis_tuser,   // req_type

    // Result stream.
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [ODW-1:0] m_axis_tdata,   // current_value, read_value,
                                           // item_count, zero fill
    output logic [2:0]     m_axis_tuser    // has_current, status
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    logic [DATA_WIDTH-1:0] in_word;
    logic [AW-1:0]         in_pos;

    logic [DATA_WIDTH-1:0] cur_value;
    logic [DATA_WIDTH-1:0] read_value;
    logic [CW-1:0]         item_count;
    logic                  has_current;
    t_status               status;

    // Unpack the request beat.
    assign in_word = s_axis_tdata[DATA_WIDTH-1:0];
    assign in_pos  = s_axis_tdata[DATA_WIDTH +: AW];

    // The controller sequences each request: it accepts a beat, walks the
    // item moves, writes the new word, issues the cursor and position reads,
    // and hands the result to the output register once that register is free.
    css_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    // The datapath decodes the request at acceptance, commits the new cursor
    // and count at once, and keeps the item RAM and the result register.
    css_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_req         (s_axis_tuser),
        .i_word        (in_word),
        .i_pos         (in_pos),
        .o_cur_value   (cur_value),
        .o_read_value  (read_value),
        .o_item_count  (item_count),
        .o_has_current (has_current),
        .o_status      (status)
    );

    // Pack the result beat, lowest field first.
    assign m_axis_tdata = ODW'({item_count, read_value, cur_value});
    assign m_axis_tuser = {status, has_current};

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for cursor_sequence_store. Request beats come first from
// a short directed table that covers the empty store, every request kind and
// the undefined codes, and then from random episodes that grow, shrink or mix
// the store so that it fills to capacity and empties again. Every accepted
// request runs through a cycle-free predictor of the store. The predicted
// result is queued, and each result beat is checked field by field against
// the oldest entry. Both streams idle at random. The result side holds off
// once for a long stretch, and the request side drains the pipeline now and
// then.
// ----------------------------------------------------------------------------
module tb;
    import css_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int IN_W         = 40;
    localparam int OUT_W        = 72;
    localparam int RANDOM_ITEMS = 1400;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE       = 80;
    localparam int NUM_DIRECTED = 26;

    // Request codes above REQ_READ_AT are undefined and leave the store alone.
    localparam logic [3:0] REQ_UNDEF_LO = 4'd12;
    localparam logic [3:0] REQ_UNDEF_HI = 4'd15;

    // One result beat, unpacked from tdata and tuser.
    typedef struct packed {
        logic [31:0] current_value;
        logic [31:0] read_value;
        logic [6:0]  item_count;
        logic        has_current;
        t_status     status;
    } seq_result_t;

    // One row of the directed table. When fixed is set, the result is typed
    // in the row and the predictor only keeps its state in step.
    typedef struct packed {
        logic [3:0]  code;
        logic [31:0] word;
        logic [5:0]  pos;
        logic        fixed;
        seq_result_t want;
    } plan_row_t;

    // Bias of a random episode.
    typedef enum int {
        MODE_GROW,
        MODE_SHRINK,
        MODE_MIX
    } seq_mode_t;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;   // entry_value, position, zero fill
    logic [3:0]       s_axis_tuser;   // req_type
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;   // current_value, read_value, item_count,
                                      // zero fill
    logic [2:0]       m_axis_tuser;   // has_current, status

    // Predictor state: the held words, the cursor and the count.
    logic [31:0]  stored_words [CAPACITY];
    int unsigned  cursor_at;
    int unsigned  held_count;

    seq_result_t  expected_results [$];
    int           mismatch_count;
    bit           long_hold_due;

    cursor_sequence_store uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // The directed table. The first rows start from an empty store, so the no-current
    // and range errors and the empty-store cursor moves can be typed in directly.
    plan_row_t directed_plan [NUM_DIRECTED] = '{
        '{REQ_START,        32'h0000_0000, 6'd0,  1'b1, '{32'h0, 32'h0, 7'd0, 1'b0, ST_OK}},
        '{REQ_ADVANCE,      32'h0000_0000, 6'd0,  1'b1, '{32'h0, 32'h0, 7'd0, 1'b0, ST_NO_CUR}},
        '{REQ_REMOVE_CUR,   32'h0000_0000, 6'd0,  1'b1, '{32'h0, 32'h0, 7'd0, 1'b0, ST_NO_CUR}},
        '{REQ_REMOVE_FRONT, 32'h0000_0000, 6'd0,  1'b1, '{32'h0, 32'h0, 7'd0, 1'b0, ST_NO_CUR}},
        '{REQ_READ_AT,      32'h0000_0000, 6'd63, 1'b1, '{32'h0, 32'h0, 7'd0, 1'b0, ST_RANGE}},
        '{REQ_RETREAT,      32'h0000_0000, 6'd0,  1'b1, '{32'h0, 32'h0, 7'd0, 1'b0, ST_OK}},
        '{REQ_END,          32'h0000_0000, 6'd0,  1'b1, '{32'h0, 32'h0, 7'd0, 1'b0, ST_OK}},
        // Insert with no current item lands at the front.
        '{REQ_INSERT,       32'hFFFF_FFFF, 6'd0,  1'b1,
          '{32'hFFFF_FFFF, 32'h0, 7'd1, 1'b1, ST_OK}},
        '{REQ_ATTACH,       32'h0000_0000, 6'd0,  1'b1, '{32'h0, 32'h0, 7'd2, 1'b1, ST_OK}},
        '{REQ_INSERT_FRONT, 32'hA5A5_A5A5, 6'd0,  1'b0, '0},
        '{REQ_ATTACH_BACK,  32'h5A5A_5A5A, 6'd0,  1'b0, '0},
        '{REQ_READ_AT,      32'h0000_0000, 6'd0,  1'b0, '0},
        '{REQ_READ_AT,      32'h0000_0000, 6'd3,  1'b0, '0},
        '{REQ_READ_AT,      32'h0000_0000, 6'd4,  1'b0, '0},
        // Cursor parked at the top of the store, past every held item.
        '{REQ_LAST,         32'h0000_0000, 6'd0,  1'b0, '0},
        '{REQ_ADVANCE,      32'h0000_0000, 6'd0,  1'b0, '0},
        '{REQ_RETREAT,      32'h0000_0000, 6'd0,  1'b0, '0},
        // Attach with no current item lands at the back.
        '{REQ_ATTACH,       32'h1234_5678, 6'd0,  1'b0, '0},
        '{REQ_INSERT,       32'h8765_4321, 6'd0,  1'b0, '0},
        '{REQ_END,          32'h0000_0000, 6'd0,  1'b0, '0},
        '{REQ_REMOVE_CUR,   32'h0000_0000, 6'd0,  1'b0, '0},
        '{REQ_INSERT,       32'hDEAD_BEEF, 6'd0,  1'b0, '0},
        '{REQ_ADVANCE,      32'h0000_0000, 6'd0,  1'b0, '0},
        '{REQ_REMOVE_FRONT, 32'h0000_0000, 6'd0,  1'b0, '0},
        // Undefined codes with every data bit set.
        '{REQ_UNDEF_LO,     32'hFFFF_FFFF, 6'd63, 1'b0, '0},
        '{REQ_UNDEF_HI,     32'hFFFF_FFFF, 6'd63, 1'b0, '0}
    };

    // Opens a gap at slot and writes word into it.
    function automatic void open_slot(int unsigned slot, logic [31:0] word);
        int unsigned k;
        for (k = held_count; k > slot; k--) begin
            stored_words[k] = stored_words[k-1];
        end
        stored_words[slot] = word;
        held_count++;
    endfunction

    // Closes the slot and pulls later items forward.
    function automatic void close_slot(int unsigned slot);
        int unsigned k;
        for (k = slot + 1; k < held_count; k++) begin
            stored_words[k-1] = stored_words[k];
        end
        held_count--;
    endfunction

    // Applies one request to the predictor state and returns the result
    // beat that the store must produce for it.
    function automatic seq_result_t apply_request(logic [3:0] code, logic [31:0] word,
                                                  logic [5:0] pos);
        seq_result_t r;
        bit          full;
        bit          has_cur;
        r = '0;
        r.status = ST_OK;
        full = (held_count >= CAPACITY);
        has_cur = (cursor_at < held_count);
        case (code)
            REQ_START: begin
                cursor_at = 0;
            end
            REQ_END: begin
                cursor_at = (held_count != 0) ? held_count - 1 : 0;
            end
            REQ_LAST: begin
                cursor_at = CAPACITY - 1;
            end
            REQ_ADVANCE: begin
                if (!has_cur) r.status = ST_NO_CUR;
                else cursor_at++;
            end
            REQ_RETREAT: begin
                if (cursor_at != 0) cursor_at--;
            end
            REQ_INSERT: begin
                if (full) begin
                    r.status = ST_FULL;
                end else begin
                    if (!has_cur) cursor_at = 0;
                    open_slot(cursor_at, word);
                end
            end
            REQ_ATTACH: begin
                if (full) begin
                    r.status = ST_FULL;
                end else begin
                    if (!has_cur) cursor_at = held_count;
                    else cursor_at++;
                    open_slot(cursor_at, word);
                end
            end
            REQ_REMOVE_CUR: begin
                if (!has_cur) r.status = ST_NO_CUR;
                else close_slot(cursor_at);
            end
            REQ_INSERT_FRONT: begin
                if (full) begin
                    r.status = ST_FULL;
                end else begin
                    cursor_at = 0;
                    open_slot(0, word);
                end
            end
            REQ_ATTACH_BACK: begin
                if (full) begin
                    r.status = ST_FULL;
                end else begin
                    cursor_at = held_count;
                    open_slot(cursor_at, word);
                end
            end
            REQ_REMOVE_FRONT: begin
                if (!has_cur) begin
                    r.status = ST_NO_CUR;
                end else begin
                    close_slot(0);
                    cursor_at = 0;
                end
            end
            REQ_READ_AT: begin
                if (pos >= held_count) r.status = ST_RANGE;
                else r.read_value = stored_words[pos];
            end
            default: begin
            end
        endcase
        r.has_current = (cursor_at < held_count);
        r.current_value = r.has_current ? stored_words[cursor_at] : 32'h0;
        r.item_count = held_count[6:0];
        return r;
    endfunction

    // Idle length for either stream: mostly none, often short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Request code for a random beat, skewed by the episode's bias.
    function automatic logic [3:0] pick_code(seq_mode_t mode);
        logic [3:0] code;
        int         r;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 24) == 0) code = 4'($urandom_range(REQ_UNDEF_LO, REQ_UNDEF_HI));
        else code = 4'($urandom_range(REQ_START, REQ_READ_AT));
        case (mode)
            MODE_GROW: begin
                if (r < 80) begin
                    case ($urandom_range(0, 3))
                        0: code = REQ_INSERT;
                        1: code = REQ_ATTACH;
                        2: code = REQ_INSERT_FRONT;
                        default: code = REQ_ATTACH_BACK;
                    endcase
                end
            end
            MODE_SHRINK: begin
                if (r < 40) code = REQ_REMOVE_CUR;
                else if (r < 60) code = REQ_REMOVE_FRONT;
                else if (r < 70) code = REQ_START;
            end
            default: begin
            end
        endcase
        return code;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("%0t: %s got %h, want %h", $realtime, what, got, want);
    endtask

    // Offers one request beat after a random idle gap and, once it is taken,
    // queues the result the store must give for it. Called at a falling edge
    // and returns at the falling edge after acceptance.
    task automatic send_request(logic [3:0] code, logic [31:0] word, logic [5:0] pos,
                                bit fixed, seq_result_t fixed_want, bit steady);
        int          gap;
        seq_result_t predicted;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {2'b0, pos, word};
        s_axis_tuser  = code;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = apply_request(code, word, pos);
        expected_results.push_back(fixed ? fixed_want : predicted);
        @(negedge i_clk);
    endtask

    // Stops offering requests until every queued result has come back.
    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        do @(negedge i_clk); while (expected_results.size() != 0);
    endtask

    // Request side: reset, the directed table, then random episodes.
    initial begin : request_source
        seq_mode_t   mode;
        int          episode;
        int          span;
        int          n;
        int          random_sent;
        bit          steady;
        logic [3:0]  code;
        logic [31:0] word;
        logic [5:0]  pos;

        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        mismatch_count = 0;
        long_hold_due  = 1'b0;
        cursor_at      = 0;
        held_count     = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_request(directed_plan[i].code, directed_plan[i].word, directed_plan[i].pos,
                         directed_plan[i].fixed, directed_plan[i].want, 1'b0);
        end
        drain_results();

        // The first episode fills the store to capacity and keeps pushing so
        // that the full status shows up; the second one empties it again.
        // The third runs back to back while the result side holds off.
        episode = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if (episode == 0) begin
                mode = MODE_GROW;
                span = 150;
            end else if (episode == 1) begin
                mode = MODE_SHRINK;
                span = 150;
            end else begin
                mode = seq_mode_t'($urandom_range(MODE_GROW, MODE_MIX));
                span = $urandom_range(20, 150);
            end
            steady = ($urandom_range(0, 4) == 0) || (episode == 2);
            if (episode == 2) long_hold_due = 1'b1;
            for (n = 0; n < span && random_sent < RANDOM_ITEMS; n++) begin
                code = pick_code(mode);
                word = ($urandom_range(0, 9) == 0) ? {32{$urandom_range(0, 1) == 1}}
                                                   : $urandom;
                if (code == REQ_READ_AT && held_count != 0 && $urandom_range(0, 3) != 0) begin
                    pos = 6'($urandom_range(0, held_count - 1));
                end else begin
                    pos = 6'($urandom_range(0, CAPACITY - 1));
                end
                send_request(code, word, pos, 1'b0, '0, steady);
                if (code < REQ_UNDEF_LO) random_sent++;
            end
            if ($urandom_range(0, 2) == 0) drain_results();
            episode++;
        end

        s_axis_tvalid = 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("cursor_sequence_store: match");
        end else begin
            $display("cursor_sequence_store: mismatch");
        end
        $finish;
    end

    // Result side: ready runs of random length, broken by stalls. One stall
    // is a long hold-off so that the store backs up and stalls its input; a
    // ready run is cut short as soon as that hold-off is requested.
    initial begin : result_sink
        int run_len;
        int stall_len;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            m_axis_tready = 1'b1;
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 12);
            for (int c = 0; c < run_len && !long_hold_due; c++) begin
                @(negedge i_clk);
            end
            if (long_hold_due) begin
                long_hold_due = 1'b0;
                stall_len = LONG_HOLD;
            end else begin
                stall_len = pick_gap();
            end
            if (stall_len > 0) begin
                m_axis_tready = 1'b0;
                repeat (stall_len) @(negedge i_clk);
            end
        end
    end

    // Every result beat is matched against the oldest queued expectation.
    always @(posedge i_clk) begin : result_check
        seq_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result beat with nothing pending", m_axis_tdata[31:0], '0);
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tdata[31:0] !== want.current_value)
                    report_mismatch("current_value", m_axis_tdata[31:0], want.current_value);
                if (m_axis_tdata[63:32] !== want.read_value)
                    report_mismatch("read_value", m_axis_tdata[63:32], want.read_value);
                if (m_axis_tdata[70:64] !== want.item_count)
                    report_mismatch("item_count", 32'(m_axis_tdata[70:64]),
                                    32'(want.item_count));
                if (m_axis_tuser[0] !== want.has_current)
                    report_mismatch("has_current", 32'(m_axis_tuser[0]),
                                    32'(want.has_current));
                if (m_axis_tuser[2:1] !== want.status)
                    report_mismatch("status", 32'(m_axis_tuser[2:1]), 32'(want.status));
            end
        end
    end

    // Safety net in case the store hangs.
    initial begin : watchdog
        #10_000_000;
        $display("cursor_sequence_store: mismatch");
        $finish;
    end

endmodule
